### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Screen geometry, field layout, request codes, state and command types.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // Screen geometry
   localparam int ROWS       = 25;
   localparam int COLS       = 80;
   localparam int TAB_STOP   = 8;
   localparam int CELL_COUNT = ROWS * COLS;
   localparam int COPY_LAST  = (ROWS - 1) * COLS;
   localparam int NUM_STOPS  = (COLS - 1) / TAB_STOP + 1;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int ROWX_W = ROW_W + 1;
   localparam int COL_W  = $clog2(COLS);
   localparam int COLX_W = $clog2(COLS + TAB_STOP);
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CELL_W = 16;

   // Field widths
   localparam int REQ_TYPE_W = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int TROW_W     = 5;
   localparam int TCOL_W     = 7;
   localparam int CUR_ROW_W  = 5;
   localparam int CUR_COL_W  = 7;
   localparam int CUR_LIN_W  = 11;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USED_W = CUR_ROW_W + CUR_COL_W + CUR_LIN_W + CELL_W;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd3;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
   localparam logic [CELL_W-1:0] INIT_CELL  = 16'h0720;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } tcce_state_type;

   // Write data source for the screen store
   typedef enum logic [1:0] {
      WR_EXEC,
      WR_COPY,
      WR_BLANK,
      WR_INIT
   } tcce_wsel_type;

   typedef struct packed {
      logic          capture;
      logic          exec;
      logic          wr_en;
      tcce_wsel_type wsel;
      logic          rd_scan;
      logic          latch_word;
      logic          scan_zero;
      logic          scan_step;
      logic          load_rsp;
   } tcce_cmd_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic                  scroll_need;
      logic                  copy_end;
      logic                  scan_end;
   } tcce_stat_type;

   // Next tab stop strictly above the column
   function automatic logic [COLX_W-1:0] tab_next(input logic [COL_W-1:0] col);
      logic [COLX_W-1:0] res;
      res = COLX_W'(TAB_STOP);
      for (int k = NUM_STOPS; k >= 1; k--) begin
         if (COLX_W'(col) < COLX_W'(k * TAB_STOP)) begin
            res = COLX_W'(k * TAB_STOP);
         end
      end
      return res;
   endfunction

endpackage

### rtl/tcce_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// Console controller
// Sequences request execution, store sweeps and the response register.
// ----------------------------------------------------------------------------
module tcce_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  tcce_pkg::tcce_stat_type stat,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tcce_pkg::tcce_cmd_type cmd
);
   import tcce_pkg::*;

   tcce_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:   if (stat.scan_end) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: begin
            case (stat.kind)
               REQ_PUT:   state_in = stat.scroll_need ? ST_SCROLL : ST_DONE;
               REQ_READ:  state_in = ST_READ;
               REQ_CLEAR: state_in = ST_FILL;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_READ:   state_in = ST_DONE;
         ST_SCROLL: if (stat.copy_end) state_in = ST_FILL;
         ST_FILL:   if (stat.scan_end) state_in = ST_DONE;
         ST_DONE:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      cmd.wsel   = WR_EXEC;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.wr_en     = 1'b1;
            cmd.wsel      = WR_INIT;
            cmd.scan_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.wr_en     = 1'b1;
            cmd.wsel      = WR_EXEC;
            cmd.scan_zero = 1'b1;
         end
         ST_READ: begin
            cmd.latch_word = 1'b1;
         end
         ST_SCROLL: begin
            cmd.rd_scan   = 1'b1;
            cmd.wr_en     = 1'b1;
            cmd.wsel      = WR_COPY;
            cmd.scan_step = !stat.copy_end;
         end
         ST_FILL: begin
            cmd.wr_en     = 1'b1;
            cmd.wsel      = WR_BLANK;
            cmd.scan_step = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Response valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/tcce_dp.sv
// ----------------------------------------------------------------------------
// Console datapath
// Cursor, request fields, screen store addressing and response register.
// ----------------------------------------------------------------------------
module tcce_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcce_pkg::tcce_cmd_type               cmd,
   output tcce_pkg::tcce_stat_type              stat,
   input  logic [tcce_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [tcce_pkg::REQ_TYPE_W-1:0]      req_tuser,
   input  logic                                 csr_valid,
   input  logic [tcce_pkg::ATTR_W-1:0]          csr_data,
   output logic [tcce_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import tcce_pkg::*;

   // Captured request
   logic [REQ_TYPE_W-1:0] kind_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic [ATTR_W-1:0]     cattr_ff;
   logic [TROW_W-1:0]     trow_ff;
   logic [TCOL_W-1:0]     tcol_ff;

   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ATTR_W-1:0]     tattr_ff, tattr_in;
   logic [ADDR_W-1:0]     scan_ff, scan_in;
   logic [CELL_W-1:0]     word_ff, word_in;
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic                  in_range;
   logic [ADDR_W-1:0]     lin;
   logic [ADDR_W-1:0]     tgt_addr;
   logic [CELL_W-1:0]     blank;

   logic [ROWX_W-1:0]     put_row;
   logic [COLX_W-1:0]     put_col;
   logic                  put_we;
   logic [ADDR_W-1:0]     put_addr;
   logic [CELL_W-1:0]     put_data;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [CELL_W-1:0]     ram_wdata;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [CELL_W-1:0]     ram_rdata;

   assign blank    = {tattr_ff, CH_SPACE};
   assign in_range = (32'(trow_ff) < ROWS) && (32'(tcol_ff) < COLS);
   assign lin      = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLS) + ADDR_W'(col_ff));
   assign tgt_addr = ADDR_W'(ADDR_W'(trow_ff) * ADDR_W'(COLS) + ADDR_W'(tcol_ff));

   // Put character: interpret control bytes, advance and wrap
   always_comb begin
      put_row  = ROWX_W'(row_ff);
      put_col  = COLX_W'(col_ff);
      put_we   = 1'b0;
      put_addr = lin;
      put_data = {tattr_ff, char_ff};
      case (char_ff)
         CH_NL: begin
            put_col = '0;
            put_row = ROWX_W'(row_ff) + 1'b1;
         end
         CH_CR: begin
            put_col = '0;
         end
         CH_TAB: begin
            put_col = tab_next(col_ff);
         end
         CH_BS: begin
            if (col_ff != '0) begin
               put_col  = COLX_W'(col_ff) - 1'b1;
               put_we   = 1'b1;
               put_addr = lin - 1'b1;
               put_data = blank;
            end
         end
         default: begin
            put_col = COLX_W'(col_ff) + 1'b1;
            put_we  = 1'b1;
         end
      endcase
      if (put_col >= COLX_W'(COLS)) begin
         put_col = '0;
         put_row = put_row + 1'b1;
      end
   end

   assign stat.kind        = kind_ff;
   assign stat.scroll_need = (put_row >= ROWX_W'(ROWS));
   assign stat.copy_end    = (scan_ff == ADDR_W'(COPY_LAST));
   assign stat.scan_end    = (scan_ff == ADDR_W'(CELL_COUNT - 1));

   // Select the store write source
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = scan_ff;
      ram_wdata = blank;
      case (cmd.wsel)
         WR_EXEC: begin
            if (kind_ff == REQ_PUT) begin
               ram_we    = cmd.wr_en && put_we;
               ram_waddr = put_addr;
               ram_wdata = put_data;
            end else begin
               ram_we    = cmd.wr_en && (kind_ff == REQ_WRITE) && in_range;
               ram_waddr = tgt_addr;
               ram_wdata = {cattr_ff, char_ff};
            end
         end
         WR_COPY: begin
            ram_we    = cmd.wr_en && (scan_ff != '0);
            ram_waddr = scan_ff - 1'b1;
            ram_wdata = ram_rdata;
         end
         WR_BLANK: begin
            ram_we    = cmd.wr_en;
            ram_wdata = blank;
         end
         WR_INIT: begin
            ram_we    = cmd.wr_en;
            ram_wdata = INIT_CELL;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Read one row ahead while copying (the current cell at the copy end), else the target cell
   always_comb begin
      ram_raddr = tgt_addr;
      if (cmd.rd_scan) begin
         ram_raddr = stat.copy_end ? scan_ff : ADDR_W'(scan_ff + ADDR_W'(COLS));
      end
   end

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Cursor update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.exec) begin
         if (kind_ff == REQ_PUT) begin
            row_in = stat.scroll_need ? ROW_W'(ROWS - 1) : ROW_W'(put_row);
            col_in = COL_W'(put_col);
         end else if (kind_ff == REQ_CLEAR) begin
            row_in = '0;
            col_in = '0;
         end
      end
   end

   // Sweep counter
   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_zero) begin
         scan_in = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   assign tattr_in = csr_valid ? csr_data : tattr_ff;

   // Read word: cleared at capture, loaded from the store on a read (zero when out of range)
   always_comb begin
      word_in = word_ff;
      if (cmd.capture) begin
         word_in = '0;
      end else if (cmd.latch_word) begin
         word_in = in_range ? ram_rdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         tattr_ff <= ATTR_RESET;
         scan_ff  <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         tattr_ff <= tattr_in;
         scan_ff  <= scan_in;
      end
   end

   // Request capture and response register
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (cmd.capture) begin
         kind_ff  <= req_tuser;
         char_ff  <= req_tdata[7:0];
         cattr_ff <= req_tdata[15:8];
         trow_ff  <= req_tdata[20:16];
         tcol_ff  <= req_tdata[27:21];
      end
      if (cmd.load_rsp) begin
         rsp_ff <= {{(RSP_DATA_W - RSP_USED_W){1'b0}}, word_ff, CUR_LIN_W'(lin),
                    CUR_COL_W'(col_ff), CUR_ROW_W'(row_ff)};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

### rtl/text_console_cursor_engine_top.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell console writer over a 25x80 screen store of 16-bit cells.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the screen store once, one cell per cycle,
// writing the blank cell 0x0720 to all ROWS*COLS cells; requests wait until
// that pass ends, attribute writes are taken at any time. One request is in
// work at a time. Put character and write cell pass through EXEC and DONE
// from accept to response; read cell adds READ for the registered store read.
// A put character that scrolls copies the store up one row through the
// single write port, with the first copy write held off while the read is
// primed, and then blanks the last row. Clear screen walks every cell. The
// response sits in an output register, so the next request is taken while
// it waits.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: char_code[7:0], cell_attribute[15:8], target_row[20:16],
   //            target_col[27:21], zero pad [31:28]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: cur_row[4:0], cur_col[11:5], cur_linear[22:12],
   //            cell_word[38:23], zero pad [39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // csr_data: text_attribute
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import tcce_pkg::*;

   tcce_cmd_type  cmd;
   tcce_stat_type stat;

   assign csr_ready = 1'b1;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tcce_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

   // Only one request in work: no accept in the cycle after an accept
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

   // Reported cursor row stays on screen
   a_row_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[4:0]) < ROWS))
      else $error("cursor row beyond last row");

   // Reported cursor column stays on screen
   a_col_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[11:5]) < COLS))
      else $error("cursor column beyond last column");

   // Store sweep never overlaps a response load or a request capture in the same cycle
   a_sweep_excl : assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !cmd.load_rsp && !cmd.capture)
      else $error("sweep overlaps request handling");

endmodule
